FILE: rtl/pfdc_pkg.sv
package pfdc_pkg;

  // Default depth of the job queue between front and back
  localparam int QueueDepthDefault = 2;

  // Key square storage
  localparam int SqDepth  = 25;
  localparam int PosDepth = 26;

  // Op codes of the input item
  localparam logic [2:0] OpClear  = 3'd0;
  localparam logic [2:0] OpKey    = 3'd1;
  localparam logic [2:0] OpFinish = 3'd2;
  localparam logic [2:0] OpText   = 3'd3;
  localparam logic [2:0] OpEnd    = 3'd4;

  // Letter codes, A = 0
  localparam logic [4:0] LetI = 5'd8;
  localparam logic [4:0] LetJ = 5'd9;
  localparam logic [4:0] LetQ = 5'd16;
  localparam logic [4:0] LetX = 5'd23;
  localparam logic [4:0] LetZ = 5'd25;

  localparam logic [7:0] AsciiUpA = 8'h41;
  localparam logic [7:0] AsciiUpZ = 8'h5A;
  localparam logic [7:0] AsciiLoA = 8'h61;
  localparam logic [7:0] AsciiLoZ = 8'h7A;
  localparam logic [7:0] AsciiCaseOfs = 8'h20;
  localparam logic [6:0] AsciiBase = 7'h41;

  // One unit of work for the back end: an error result or a letter pair
  typedef struct packed {
    logic       err;
    logic [4:0] a;
    logic [4:0] b;
  } pfdc_job_t;

  // Key square write port, driven by the front end into both tables
  typedef struct packed {
    logic       we;
    logic [4:0] sq_addr;
    logic [4:0] sq_data;
    logic [4:0] pos_addr;
    logic [4:0] pos_data;
  } pfdc_key_wr_t;

  // Row of a square position 0..24
  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) begin
      r = 3'd4;
    end else if (p >= 5'd15) begin
      r = 3'd3;
    end else if (p >= 5'd10) begin
      r = 3'd2;
    end else if (p >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  // Square position from row and column
  function automatic logic [4:0] pos_index(input logic [2:0] r, input logic [2:0] c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

  // Column of a square position 0..24
  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] t;
    t = p - pos_index(pos_row(p), 3'd0);
    return t[2:0];
  endfunction

  // (v + sh) mod 5 for v in 0..4, sh in 1..4
  function automatic logic [2:0] add_mod5(input logic [2:0] v, input logic [2:0] sh);
    logic [3:0] s;
    s = {1'b0, v} + {1'b0, sh};
    if (s >= 4'd5) begin
      s = s - 4'd5;
    end
    return s[2:0];
  endfunction

endpackage

FILE: rtl/pfdc_ram.sv
module pfdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pfdc_queue.sv
module pfdc_queue import pfdc_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  pfdc_job_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output pfdc_job_t pop_data
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  pfdc_job_t       entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/pfdc_front.sv
module pfdc_front import pfdc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,
  input  logic         quiet,
  output logic         job_valid,
  input  logic         job_ready,
  output pfdc_job_t    job,
  output pfdc_key_wr_t key_wr
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FILL} state_t;

  state_t      state;
  logic [2:0]  item_op;
  logic [7:0]  item_ch;
  logic [25:0] present;
  logic [4:0]  key_count;
  logic        key_ready;
  logic [4:0]  pend_letter;
  logic        pend_valid;
  logic [4:0]  fill_code;

  logic [7:0]  key_upper;
  logic [7:0]  key_off;
  logic        key_is_letter;
  logic [4:0]  key_code;
  logic [7:0]  text_off;
  logic        text_is_letter;
  logic [4:0]  text_code;
  logic [4:0]  place_code;
  logic        place_ok;
  logic        exec_done;

  assign s_tready = (state == S_IDLE);

  // Key byte: fold to upper case, J becomes I
  assign key_upper = (item_ch >= AsciiLoA && item_ch <= AsciiLoZ) ? item_ch - AsciiCaseOfs
                                                                 : item_ch;
  assign key_is_letter = (key_upper >= AsciiUpA) && (key_upper <= AsciiUpZ);
  assign key_off  = key_upper - AsciiUpA;
  assign key_code = (key_off[4:0] == LetJ) ? LetI : key_off[4:0];

  // Text byte: upper case only
  assign text_is_letter = (item_ch >= AsciiUpA) && (item_ch <= AsciiUpZ);
  assign text_off  = item_ch - AsciiUpA;
  assign text_code = (text_off[4:0] == LetJ) ? LetI : text_off[4:0];

  assign place_code = (state == S_FILL) ? fill_code : key_code;
  assign place_ok   = !present[place_code] && (key_count < 5'(SqDepth));

  always_comb begin
    key_wr.we       = 1'b0;
    key_wr.sq_addr  = key_count;
    key_wr.sq_data  = place_code;
    key_wr.pos_addr = place_code;
    key_wr.pos_data = key_count;
    if (state == S_EXEC && item_op == OpKey && quiet && !key_ready && key_is_letter) begin
      key_wr.we = place_ok;
    end else if (state == S_FILL && fill_code != LetJ) begin
      key_wr.we = place_ok;
    end
  end

  // Classify text and end items into queue jobs
  always_comb begin
    job_valid = 1'b0;
    job       = '0;
    if (state == S_EXEC) begin
      if (item_op == OpText) begin
        if (!key_ready || !text_is_letter) begin
          job_valid = 1'b1;
          job.err   = 1'b1;
        end else if (pend_valid) begin
          job_valid = 1'b1;
          if (pend_letter == text_code) begin
            job.a = text_code;
            job.b = (text_code == LetX) ? LetQ : LetX;
          end else begin
            job.a = pend_letter;
            job.b = text_code;
          end
        end
      end else if (item_op == OpEnd) begin
        if (!key_ready) begin
          job_valid = 1'b1;
          job.err   = 1'b1;
        end else if (pend_valid) begin
          job_valid = 1'b1;
          job.a     = pend_letter;
          job.b     = LetZ;
        end
      end
    end
  end

  // Key changes wait for the back end to drain; jobs wait for queue space
  always_comb begin
    if (item_op == OpClear || item_op == OpKey || item_op == OpFinish) begin
      exec_done = quiet;
    end else if (job_valid) begin
      exec_done = job_ready;
    end else begin
      exec_done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      present     <= '0;
      key_count   <= '0;
      key_ready   <= 1'b0;
      pend_letter <= '0;
      pend_valid  <= 1'b0;
      fill_code   <= '0;
    end else begin
      if (key_wr.we) begin
        present[place_code] <= 1'b1;
        key_count           <= key_count + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            item_op <= s_tdata[2:0];
            item_ch <= s_tdata[10:3];
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_done) begin
            if (item_op == OpFinish && !key_ready) begin
              fill_code <= '0;
              state     <= S_FILL;
            end else begin
              state <= S_IDLE;
            end
            unique case (item_op)
              OpClear: begin
                present     <= '0;
                key_count   <= '0;
                key_ready   <= 1'b0;
                pend_letter <= '0;
                pend_valid  <= 1'b0;
              end
              OpText: begin
                if (key_ready && text_is_letter) begin
                  if (!pend_valid) begin
                    pend_letter <= text_code;
                    pend_valid  <= 1'b1;
                  end else if (pend_letter != text_code) begin
                    pend_valid <= 1'b0;
                  end
                end
              end
              OpEnd: begin
                if (key_ready) begin
                  pend_valid <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          fill_code <= fill_code + 1'b1;
          if (fill_code == LetZ) begin
            key_ready <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/pfdc_back.sv
module pfdc_back import pfdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  pfdc_job_t  job,
  input  logic       decrypt_mode,
  output logic [4:0] pos_raddr,
  input  logic [4:0] pos_rdata,
  output logic [4:0] sq_raddr,
  input  logic [4:0] sq_rdata,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tuser,
  output logic       m_tlast,
  output logic       idle
);

  typedef enum logic [2:0] {
    B_IDLE, B_POSA, B_POSB, B_SQA, B_SQB, B_EMITA, B_EMITB
  } state_t;

  state_t     state;
  logic [4:0] job_b;
  logic [4:0] pa;
  logic [4:0] nb_r;
  logic [6:0] res_a;
  logic [6:0] res_b_letter;
  logic       res_b_err;
  logic [6:0] out_letter;
  logic       out_err;
  logic       out_last;

  logic [2:0] ra, ca, rb, cb, sh;
  logic [4:0] na, nb;
  logic       out_free;
  logic       out_load;

  assign ra = pos_row(pa);
  assign ca = pos_col(pa);
  assign rb = pos_row(pos_rdata);
  assign cb = pos_col(pos_rdata);
  assign sh = decrypt_mode ? 3'd4 : 3'd1;

  // Row, column and rectangle rules
  always_comb begin
    if (ra == rb) begin
      na = pos_index(ra, add_mod5(ca, sh));
      nb = pos_index(rb, add_mod5(cb, sh));
    end else if (ca == cb) begin
      na = pos_index(add_mod5(ra, sh), ca);
      nb = pos_index(add_mod5(rb, sh), cb);
    end else begin
      na = pos_index(ra, cb);
      nb = pos_index(rb, ca);
    end
  end

  assign pos_raddr = (state == B_IDLE) ? job.a : job_b;
  assign sq_raddr  = (state == B_SQA) ? nb_r : na;
  assign job_ready = (state == B_IDLE);
  assign idle      = (state == B_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && (state == B_EMITA || state == B_EMITB);

  assign m_tdata = {1'b0, out_letter};
  assign m_tuser = out_err;
  assign m_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            job_b <= job.b;
            if (job.err) begin
              res_b_letter <= '0;
              res_b_err    <= 1'b1;
              state        <= B_EMITB;
            end else begin
              state <= B_POSA;
            end
          end
        end
        B_POSA: begin
          pa    <= pos_rdata;
          state <= B_POSB;
        end
        B_POSB: begin
          nb_r  <= nb;
          state <= B_SQA;
        end
        B_SQA: begin
          res_a <= AsciiBase + {2'b00, sq_rdata};
          state <= B_SQB;
        end
        B_SQB: begin
          res_b_letter <= AsciiBase + {2'b00, sq_rdata};
          res_b_err    <= 1'b0;
          state        <= B_EMITA;
        end
        B_EMITA: begin
          if (out_free) begin
            out_letter <= res_a;
            out_err    <= 1'b0;
            out_last   <= 1'b0;
            state      <= B_EMITB;
          end
        end
        B_EMITB: begin
          if (out_free) begin
            out_letter <= res_b_letter;
            out_err    <= res_b_err;
            out_last   <= 1'b1;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/playfair_digraph_cipher_top.sv
// Playfair cipher engine over a 5x5 key square.
// Input stream (s_*): one item per op. s_tdata[2:0] = op, s_tdata[10:3] = char_in.
//   Ops: clear key, key byte, finish key, text letter, end of text.
// Output stream (m_*): cipher letters in m_tdata[6:0] (ASCII A..Z), m_tuser flags
//   an error result (letter 0), m_tlast marks the last result of one input item.
// Config: cfg_we/cfg_wdata write decrypt_mode (0 encrypt, 1 decrypt); write only
//   while the block is idle.
// Flow: the front end takes one item at a time; s_tready stays low until the item
//   is executed. Finish key sweeps all 26 letter codes and holds the front end
//   meanwhile. A pair job in the back end makes two reads of the letter-position
//   table and two reads of the square, one port each, then two output beats; an
//   error job goes straight to its single output beat. The back end takes no new
//   job until the last beat of the current one is loaded, so sustained text is
//   bound by the serial back end, most of all when every letter is doubled.
// Key ops wait in the front end until the job queue and back end have drained, so
//   the square never changes under a pending lookup.
// Reset: empty square, key not finished, nothing pending, encrypt mode. The square
//   tables themselves are not cleared; they are fully written before any lookup.
// Stall: a held m_tready freezes the output register and the back end; the queue
//   keeps taking items until full, then the front end drops s_tready.
module playfair_digraph_cipher_top import pfdc_pkg::*; #(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [2:0] op, [10:3] char_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] letter_out
  output logic        m_tuser,   // [0] error
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic         decrypt_mode;
  pfdc_key_wr_t key_wr;
  logic         push_valid;
  logic         push_ready;
  pfdc_job_t    push_job;
  logic         pop_valid;
  logic         pop_ready;
  pfdc_job_t    pop_job;
  logic         back_idle;
  logic         back_quiet;
  logic [4:0]   pos_raddr;
  logic [4:0]   pos_rdata;
  logic [4:0]   sq_raddr;
  logic [4:0]   sq_rdata;

  // Hold the mode register; to be written only between runs, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      decrypt_mode <= cfg_wdata;
    end
  end

  // Back end has nothing in flight and nothing queued
  assign back_quiet = back_idle && !pop_valid;

  pfdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .quiet     (back_quiet),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job),
    .key_wr    (key_wr)
  );

  pfdc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_job)
  );

  // Square: position -> letter code
  pfdc_ram #(
    .Width (5),
    .Depth (SqDepth)
  ) u_sq_ram (
    .clk   (clk),
    .we    (key_wr.we),
    .waddr (key_wr.sq_addr),
    .wdata (key_wr.sq_data),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  // Letter code -> position
  pfdc_ram #(
    .Width (5),
    .Depth (PosDepth)
  ) u_pos_ram (
    .clk   (clk),
    .we    (key_wr.we),
    .waddr (key_wr.pos_addr),
    .wdata (key_wr.pos_data),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  pfdc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (pop_valid),
    .job_ready    (pop_ready),
    .job          (pop_job),
    .decrypt_mode (decrypt_mode),
    .pos_raddr    (pos_raddr),
    .pos_rdata    (pos_rdata),
    .sq_raddr     (sq_raddr),
    .sq_rdata     (sq_rdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .idle         (back_idle)
  );

  // Square writes only happen with no lookup pending or running
  a_key_wr_quiet: assert property (@(posedge clk) disable iff (rst)
    key_wr.we |-> back_quiet)
    else $error("key square written while back end busy");

  // An error result is a single beat carrying letter zero
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'd0))
    else $error("malformed error result");

  // Front end never pushes a job in the cycle it takes a new item
  a_push_exec: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !push_valid)
    else $error("job pushed outside execute step");

endmodule
